[design/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types for the circular deque: command and status codes, and the
// control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cdq_op_e;

  // Outcome reported with every result item.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_RESERVED = 2'd3
  } cdq_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input item
    logic update;   // apply the operation to pointers, count and ring
    logic read;     // read front and back slots of the ring
    logic load;     // load the result register
  } cdq_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } cdq_stat_t;

  localparam int unsigned OpW     = 2;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 4;

endpackage

`default_nettype wire

[design/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the circular deque: accepts one item, then steps it through
// update, ring read and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cdq_pkg::cdq_stat_t stat_i,
  output cdq_pkg::cdq_ctrl_t      ctrl_o
);
  import cdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_READ   = 4'b0100,
    S_LOAD   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_UPDATE;
      S_UPDATE: state_d = S_READ;
      S_READ:   state_d = S_LOAD;
      S_LOAD:   if (!stat_i.out_stall) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands to the datapath.
  assign in_ready_o     = (state_q == S_IDLE);
  assign ctrl_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign ctrl_o.update  = (state_q == S_UPDATE);
  assign ctrl_o.read    = (state_q == S_READ);
  assign ctrl_o.load    = (state_q == S_LOAD) && !stat_i.out_stall;

endmodule

`default_nettype wire

[design/cdq_dp.sv]
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath of the circular deque: input register, ring memory, head and
// tail pointers, occupancy count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire cdq_pkg::cdq_ctrl_t                    ctrl_i,
  output cdq_pkg::cdq_stat_t                         stat_o,
  input  wire logic [cdq_pkg::OpW-1:0]               command_i,
  input  wire logic signed [cdq_pkg::WordW-1:0]      data_in_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [cdq_pkg::StatusW-1:0]                status_o,
  output logic signed [cdq_pkg::WordW-1:0]           front_value_o,
  output logic signed [cdq_pkg::WordW-1:0]           back_value_o,
  output logic [cdq_pkg::CountW-1:0]                 item_count_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? LastIdx : i - AW'(1);
  endfunction

  // Accepted item.
  cdq_op_e            op_q;
  logic signed [WordW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      op_q   <= cdq_op_e'(command_i);
      data_q <= data_in_i;
    end
  end

  // Pointers, count and status of the current item.
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] occ_q, occ_d;
  cdq_status_e   status_q, status_d;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    status_d = ST_OK;
    wr_en    = 1'b0;
    wr_addr  = tail_q;
    unique case (op_q)
      CMD_PUSH_FRONT: begin
        if (occ_q == FullCnt) begin
          status_d = ST_FULL;
        end else begin
          head_d  = idx_dec(head_q);
          wr_en   = 1'b1;
          wr_addr = idx_dec(head_q);
          occ_d   = occ_q + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (occ_q == FullCnt) begin
          status_d = ST_FULL;
        end else begin
          tail_d  = idx_inc(tail_q);
          wr_en   = 1'b1;
          wr_addr = tail_q;
          occ_d   = occ_q + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (occ_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          head_d = idx_inc(head_q);
          occ_d  = occ_q - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (occ_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          tail_d = idx_dec(tail_q);
          occ_d  = occ_q - CW'(1);
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      status_q <= ST_OK;
    end else if (ctrl_i.update) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      status_q <= status_d;
    end
  end

  // Ring memory: one write port, two registered read ports.
  logic signed [WordW-1:0] ring_mem [DEPTH];
  logic signed [WordW-1:0] rd_front_q, rd_back_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.update && wr_en) begin
      ring_mem[wr_addr] <= data_q;
    end
    if (ctrl_i.read) begin
      rd_front_q <= ring_mem[head_q];
      rd_back_q  <= ring_mem[idx_dec(tail_q)];
    end
  end

  // Result register.
  logic                    out_valid_q;
  logic [StatusW-1:0]      status_out_q;
  logic signed [WordW-1:0] front_q, back_q;
  logic [CountW-1:0]       count_q;
  logic [CW+CountW-1:0]    occ_ext;
  logic                    empty;

  assign occ_ext = {{CountW{1'b0}}, occ_q};
  assign empty   = (occ_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      status_out_q <= status_q;
      front_q      <= empty ? '0 : rd_front_q;
      back_q       <= empty ? '0 : rd_back_q;
      count_q      <= occ_ext[CountW-1:0];
    end
  end

  assign stat_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_out_q;
  assign front_value_o    = front_q;
  assign back_value_o     = back_q;
  assign item_count_o     = count_q;

endmodule

`default_nettype wire

[design/circular_deque.sv]
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words held in a ring of DEPTH slots.
// ----------------------------------------------------------------------------
// Each input item is one command (push front, push back, pop front, pop
// back) with a value for pushes, and yields exactly one result item carrying
// the status (ok, rejected full, rejected empty), the front and back values
// after the command (zero when empty) and the item count, masked to 4 bits.
// An occupancy count decides full and empty, so all DEPTH slots are usable,
// and the indices wrap modulo DEPTH, which need not be a power of two.
// Each item passes four steps from acceptance to a loaded result: accept,
// update of pointers and ring write, ring read of front and back slots, and
// result load; the ring's registered read port sets this sequence. A result
// left waiting in the output register delays only the load of the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items. tdata: command [1:0], data_in [33:2], zero [39:34].
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,
  // Result items. tdata: status [1:0], front_value [33:2],
  // back_value [65:34], item_count [69:66], zero [71:70].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata
);
  import cdq_pkg::*;

  cdq_ctrl_t ctrl;
  cdq_stat_t stat;

  logic [StatusW-1:0]      status;
  logic signed [WordW-1:0] front_value;
  logic signed [WordW-1:0] back_value;
  logic [CountW-1:0]       item_count;

  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (s_axis_tdata[1:0]),
    .data_in_i     (s_axis_tdata[33:2]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_o      (status),
    .front_value_o (front_value),
    .back_value_o  (back_value),
    .item_count_o  (item_count)
  );

  // Pack the result item.
  assign m_axis_tdata = {2'b00, item_count, back_value, front_value, status};

endmodule

`default_nettype wire

[bench/cdq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdq_checker
// Watches both item streams of the circular deque, keeps its own model of the
// ring, head, tail and occupancy, and compares every result item with the
// oldest expected one, field by field.
// ----------------------------------------------------------------------------

module cdq_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items. tdata: command [1:0], data_in [33:2], zero [39:34].
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // Result items. tdata: status [1:0], front_value [33:2],
  // back_value [65:34], item_count [69:66], zero [71:70].
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  import cdq_pkg::*;

  typedef struct {
    cdq_status_e        status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [3:0]         item_count;
  } deque_result_t;

  // Model of the deque state.
  logic [31:0]   ring_words [DEPTH];
  int unsigned   head_slot;
  int unsigned   tail_slot;
  int unsigned   fill_level;
  deque_result_t expected_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Applies one command to the model and returns the result it must produce.
  function automatic deque_result_t apply_command(cdq_op_e op, logic [31:0] value);
    deque_result_t res;
    res.status = ST_OK;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          res.status = ST_FULL;
        end else if (op == CMD_PUSH_FRONT) begin
          head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
          ring_words[head_slot] = value;
          fill_level++;
        end else begin
          ring_words[tail_slot] = value;
          tail_slot = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
          fill_level++;
        end
      end
      default: begin
        if (fill_level == 0) begin
          res.status = ST_EMPTY;
        end else if (op == CMD_POP_FRONT) begin
          head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
          fill_level--;
        end else begin
          tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
          fill_level--;
        end
      end
    endcase
    // An empty deque reports zero at both ends.
    if (fill_level == 0) begin
      res.front_value = '0;
      res.back_value  = '0;
    end else begin
      res.front_value = ring_words[head_slot];
      res.back_value  = ring_words[(tail_slot == 0) ? DEPTH - 1 : tail_slot - 1];
    end
    res.item_count = fill_level[3:0];
    return res;
  endfunction

  // Result items are checked before new input items are modeled, so an item
  // that arrives with nothing waiting is never hidden by a fresh expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    logic [1:0]    got_status;
    logic [31:0]   got_front;
    logic [31:0]   got_back;
    logic [3:0]    got_count;
    if (!rst_ni) begin
      head_slot  = 0;
      tail_slot  = 0;
      fill_level = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = m_axis_tdata[1:0];
        got_front  = m_axis_tdata[33:2];
        got_back   = m_axis_tdata[65:34];
        got_count  = m_axis_tdata[69:66];
        if (expected_q.size() == 0) begin
          $error("result item with no command waiting: tdata %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            fail_count_o++;
          end
          if (got_front !== want.front_value) begin
            $error("front_value: expected %h, actual %h", want.front_value, got_front);
            fail_count_o++;
          end
          if (got_back !== want.back_value) begin
            $error("back_value: expected %h, actual %h", want.back_value, got_back);
            fail_count_o++;
          end
          if (got_count !== want.item_count) begin
            $error("item_count: expected %0d, actual %0d", want.item_count, got_count);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.insert(expected_q.size(),
                          apply_command(cdq_op_e'(s_axis_tdata[1:0]),
                                        s_axis_tdata[33:2]));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[bench/tb_circular_deque.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque
// Drives command items into the circular deque and pulls result items out,
// both sides with random gaps. A short directed sequence covers empty and full
// rejection, wrap of the indices and extreme values; random bursts biased
// toward pushes, pops or neither then sweep occupancy between empty and full.
// ----------------------------------------------------------------------------

module tb_circular_deque;
  import cdq_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int          RANDOM_ITEMS = 1430;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          TAIL_CYCLES  = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // command [1:0], data_in [33:2], zero [39:34]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // status [1:0], front_value [33:2],
                               // back_value [65:34], item_count [69:66]
  int          fail_count;
  int          pending;
  int          cycles;
  logic        steady;         // no gaps on either side while set

  circular_deque #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cdq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog on the whole run.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Offers one item and returns at the falling edge after its handshake.
  // Must be called at a falling edge.
  task automatic send_cmd(input cdq_op_e op, input logic [31:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, value, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Holds the input side idle until every expected result has come out.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: runs of ready broken by stalls of random length.
  initial begin : result_sink
    int run_len;
    int stall_len;
    m_axis_tready = 1'b0;
    forever begin
      run_len   = $urandom_range(1, 20);
      stall_len = pick_gap();
      repeat (run_len) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
      repeat (stall_len) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int          sent;
    int          burst_len;
    int          push_pct;
    bit          paused;
    bit          is_pop;
    bit          is_back;
    cdq_op_e     op;
    logic [31:0] value;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    steady        = 1'b0;
    sent          = 0;
    paused        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Rejected pops on an empty deque, then one item in and out at each end.
    send_cmd(CMD_POP_FRONT, 32'h1234_5678);
    send_cmd(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    send_cmd(CMD_POP_FRONT, 32'h0);
    // Fill from both ends so the head wraps below slot zero.
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0000);
    send_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'h5555_5555);
    send_cmd(CMD_PUSH_BACK, 32'hAAAA_AAAA);
    send_cmd(CMD_PUSH_FRONT, 32'h0000_0001);
    send_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH_BACK, $urandom);
    // Full: both pushes are rejected.
    send_cmd(CMD_PUSH_FRONT, 32'hDEAD_0001);
    send_cmd(CMD_PUSH_BACK, 32'hDEAD_0002);
    // Drain from both ends, then one more rejected pop.
    repeat (4) send_cmd(CMD_POP_FRONT, $urandom);
    repeat (4) send_cmd(CMD_POP_BACK, $urandom);
    send_cmd(CMD_POP_BACK, $urandom);
    wait_for_results();

    // Random bursts, each leaning toward pushes, pops or neither.
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      steady = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
        is_pop  = ($urandom_range(0, 99) >= push_pct);
        is_back = $urandom_range(0, 1);
        op = is_pop ? (is_back ? CMD_POP_BACK : CMD_POP_FRONT)
                    : (is_back ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = 32'hFFFF_FFFF;
            default: value = 32'h0;
          endcase
        end else begin
          value = $urandom;
        end
        send_cmd(op, value);
        sent++;
      end
      steady = 1'b0;
      if (!paused && sent > RANDOM_ITEMS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end

    // Let the last results drain, then a short quiet tail.
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
